### sv/skht_pkg.sv
// shared constants, codes and types of the string key hash table
`timescale 1ns / 1ps

package skht_pkg;

    // field widths of the stream items
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int KEY_LO_W   = 64;
    localparam int KEY_HI_W   = 56;
    localparam int KEY_LEN_W  = 4;
    localparam int SLOT_W     = 7;
    localparam int KEY_BYTES  = 15;
    localparam int KEY_ALL_W  = KEY_LO_W + KEY_HI_W + KEY_LEN_W;

    // hash arithmetic: byte weighted sum, scaled, then reduced modulo table size
    localparam int HASH_MULT    = 19;
    localparam int SUM_W        = 15;
    localparam int HASH_W       = 20;
    localparam int PROBE_LINEAR = 23;

    // default geometry
    localparam int DEF_TABLE_SIZE  = 101;
    localparam int DEF_PROBE_LIMIT = 19;

    // stream packing
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 152;

    // command codes, code 3 behaves as a slot read
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_MISSING  = 3'd4,
        ST_READ     = 3'd5
    } t_status;

endpackage

### sv/skht_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module skht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/string_key_hash_table_quadratic_probe_top.sv
// top level of the string key hash table with quadratic probing
`timescale 1ns / 1ps

// Open addressing hash table of TABLE_SIZE slots holding keys of up to 15 bytes.
// One item is taken at a time; o_s_tready is high only while the block is idle.
// Add forms a byte weighted hash sum and scales it, reduces it modulo the table
// size by reciprocal multiplication, scans the slots for the key through the
// single read port of the slot memory, stopping at a match, then makes one
// probe a cycle and loads the result. Delete scans the slots, stopping at the
// first match; read goes straight to the result. The occupied flags are
// flip-flops cleared by reset, so no clearing pass is needed. Results are held
// in an output register, so a pending result does not block the next item;
// only the load of the next result waits until the held one is taken.

module string_key_hash_table_quadratic_probe_top
    import skht_pkg::*;
#(
    parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
    parameter int PROBE_LIMIT = DEF_PROBE_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // key_low, key_high, key_length, slot_index, zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // command
    input  logic [CMD_W-1:0]     i_s_tuser,
    // result items
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // slot, entry_valid, entry_hash, entry_key_low, entry_key_high,
    // entry_key_length, entry_count, zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // status
    output logic [STATUS_W-1:0]  o_m_tuser
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int J_W   = $clog2(PROBE_LIMIT + 1);
    localparam int ENT_W = KEY_ALL_W + IDX_W;
    localparam int INIT_STEP = (1 + PROBE_LINEAR) % TABLE_SIZE;
    localparam int STEP_INC  = 2 % TABLE_SIZE;
    // reciprocal of the table size, the quotient estimate is at most one low
    localparam int RECIP     = (1 << HASH_W) / TABLE_SIZE;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HASH  = 6'b000010,
        S_MOD   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_PROBE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // modular add of two values already below the table size
    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(TABLE_SIZE)) begin
            s = s - (IDX_W+1)'(TABLE_SIZE);
        end
        return s[IDX_W-1:0];
    endfunction

    t_state                r_state;
    logic [TABLE_SIZE-1:0] r_used;
    logic [CNT_W-1:0]      r_count;
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_LO_W-1:0]   r_lo;
    logic [KEY_HI_W-1:0]   r_hi;
    logic [KEY_LEN_W-1:0]  r_len;
    logic [3:0]            r_byte_idx;
    logic [SUM_W-1:0]      r_sum;
    logic [HASH_W-1:0]     r_mod_val;
    logic [HASH_W-1:0]     r_quot;
    logic                  r_mod_phase;
    logic [IDX_W-1:0]      r_home;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_issue;
    logic                  r_cmp_vld;
    logic                  r_cmp_used;
    logic [IDX_W-1:0]      r_cmp_addr;
    logic [IDX_W-1:0]      r_pos;
    logic [IDX_W-1:0]      r_step;
    logic [J_W-1:0]        r_j;
    t_status               r_status;
    logic [IDX_W-1:0]      r_slot;
    logic                  r_ent_valid;
    logic                  r_m_tvalid;
    logic [M_TDATA_W-1:0]  r_m_tdata;
    logic [STATUS_W-1:0]   r_m_tuser;

    logic [M_TDATA_W-1:0]  n_m_tdata;
    logic [KEY_LO_W-1:0]   in_lo;
    logic [KEY_HI_W-1:0]   in_hi;
    logic [KEY_LEN_W-1:0]  in_len;
    logic [SLOT_W-1:0]     in_idx;
    logic [KEY_LO_W-1:0]   lo_m;
    logic [KEY_HI_W-1:0]   hi_m;
    logic                  in_range;
    logic [IDX_W-1:0]      idx_addr;
    logic [127:0]          key_vec;
    logic [7:0]            cur_byte;
    logic [SUM_W-1:0]      weighted;
    logic [2*HASH_W-1:0]   quot_prod;
    logic [HASH_W-1:0]     rem_raw;
    logic [IDX_W-1:0]      rem_next;
    logic                  hit;
    logic                  out_load;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [ENT_W-1:0]      wr_data;
    logic [ENT_W-1:0]      rd_data;

    // input field unpacking
    assign in_lo  = i_s_tdata[63:0];
    assign in_hi  = i_s_tdata[119:64];
    assign in_len = i_s_tdata[123:120];
    assign in_idx = i_s_tdata[130:124];

    // zero the key bytes beyond the key length
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            lo_m[8*i +: 8] = (KEY_LEN_W'(i) < in_len) ? in_lo[8*i +: 8] : 8'd0;
        end
        for (int i = 0; i < 7; i++) begin
            hi_m[8*i +: 8] = (KEY_LEN_W'(i + 8) < in_len) ? in_hi[8*i +: 8] : 8'd0;
        end
    end

    // read slot range check
    assign in_range = ({25'd0, in_idx} < 32'(TABLE_SIZE));
    assign idx_addr = IDX_W'(in_idx);

    // weighted byte term of the hash sum
    assign key_vec  = {8'd0, r_hi, r_lo};
    assign cur_byte = key_vec[{r_byte_idx, 3'b000} +: 8];
    assign weighted = SUM_W'(cur_byte) * SUM_W'(r_byte_idx + 4'd1);

    // remainder by reciprocal multiplication, quotient estimate then one fix-up
    assign quot_prod = {{HASH_W{1'b0}}, r_mod_val} * (2*HASH_W)'(RECIP);
    assign rem_raw   = r_mod_val - HASH_W'(r_quot * HASH_W'(TABLE_SIZE));
    assign rem_next  = (rem_raw >= HASH_W'(TABLE_SIZE))
                     ? IDX_W'(rem_raw - HASH_W'(TABLE_SIZE))
                     : IDX_W'(rem_raw);

    // scan compare on the slot read back from memory
    assign hit = r_cmp_vld && r_cmp_used &&
                 (rd_data[KEY_ALL_W-1:0] == {r_len, r_hi, r_lo});

    assign out_load = (r_state == S_DONE) && (!r_m_tvalid || i_m_tready);

    // slot memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        wr_data = {r_home, r_len, r_hi, r_lo};
        unique case (r_state)
            S_IDLE: begin
                rd_en   = i_s_tvalid;
                rd_addr = idx_addr;
            end
            S_SCAN: begin
                rd_en = r_issue;
            end
            S_PROBE: begin
                wr_en = !r_used[r_pos];
            end
            default: begin
            end
        endcase
    end

    skht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd       <= i_s_tuser;
                        r_lo        <= lo_m;
                        r_hi        <= hi_m;
                        r_len       <= in_len;
                        r_byte_idx  <= '0;
                        r_sum       <= '0;
                        r_addr      <= '0;
                        r_issue     <= 1'b1;
                        r_cmp_vld   <= 1'b0;
                        unique case (i_s_tuser)
                            CMD_ADD: begin
                                r_ent_valid <= 1'b0;
                                r_slot      <= '0;
                                r_state     <= S_HASH;
                            end
                            CMD_DELETE: begin
                                r_ent_valid <= 1'b0;
                                r_slot      <= '0;
                                r_state     <= S_SCAN;
                            end
                            default: begin
                                r_status    <= ST_READ;
                                r_slot      <= in_range ? idx_addr : '0;
                                r_ent_valid <= in_range && r_used[idx_addr];
                                r_state     <= S_DONE;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (r_byte_idx == 4'(KEY_BYTES)) begin
                        r_mod_val   <= HASH_W'(r_sum) * HASH_W'(HASH_MULT);
                        r_mod_phase <= 1'b0;
                        r_state     <= S_MOD;
                    end else begin
                        r_sum      <= r_sum + weighted;
                        r_byte_idx <= r_byte_idx + 4'd1;
                    end
                end
                S_MOD: begin
                    // quotient estimate first, remainder in the next cycle
                    if (!r_mod_phase) begin
                        r_quot      <= quot_prod[2*HASH_W-1:HASH_W];
                        r_mod_phase <= 1'b1;
                    end else begin
                        r_home  <= rem_next;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one slot read a cycle
                    r_cmp_vld  <= r_issue;
                    r_cmp_addr <= r_addr;
                    r_cmp_used <= r_used[r_addr];
                    if (r_issue) begin
                        if (r_addr == IDX_W'(TABLE_SIZE - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + IDX_W'(1);
                        end
                    end
                    // compare the slot read in the previous cycle
                    if (hit) begin
                        if (r_cmd == CMD_DELETE) begin
                            r_used[r_cmp_addr] <= 1'b0;
                            r_count            <= r_count - CNT_W'(1);
                            r_status           <= ST_REMOVED;
                            r_slot             <= r_cmp_addr;
                        end else begin
                            r_status <= ST_PRESENT;
                        end
                        r_state <= S_DONE;
                    end else if (r_cmp_vld && r_cmp_addr == IDX_W'(TABLE_SIZE - 1)) begin
                        if (r_cmd == CMD_DELETE) begin
                            r_status <= ST_MISSING;
                            r_state  <= S_DONE;
                        end else begin
                            r_pos   <= mod_add(r_home, IDX_W'(INIT_STEP));
                            r_step  <= mod_add(IDX_W'(INIT_STEP), IDX_W'(STEP_INC));
                            r_j     <= J_W'(1);
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    // quadratic probe, the step grows by two each try
                    if (!r_used[r_pos]) begin
                        r_used[r_pos] <= 1'b1;
                        r_count       <= r_count + CNT_W'(1);
                        r_status      <= ST_INSERTED;
                        r_slot        <= r_pos;
                        r_state       <= S_DONE;
                    end else if (r_j == J_W'(PROBE_LIMIT)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_pos  <= mod_add(r_pos, r_step);
                        r_step <= mod_add(r_step, IDX_W'(STEP_INC));
                        r_j    <= r_j + J_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    // result packing, entry fields only for a read of an occupied slot
    always_comb begin
        n_m_tdata          = '0;
        n_m_tdata[6:0]     = SLOT_W'(r_slot);
        n_m_tdata[145:139] = SLOT_W'(r_count);
        if (r_ent_valid) begin
            n_m_tdata[7]       = 1'b1;
            n_m_tdata[14:8]    = SLOT_W'(rd_data[ENT_W-1:KEY_ALL_W]);
            n_m_tdata[78:15]   = rd_data[63:0];
            n_m_tdata[134:79]  = rd_data[119:64];
            n_m_tdata[138:135] = rd_data[123:120];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tuser <= r_status;
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule
